// ===== hw/rtl/u2u8_pkg.sv =====
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 encoder package
// Shared types, status codes and byte encoding functions.
// ----------------------------------------------------------------------------
package u2u8_pkg;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_FULL      = 2'd2,
    ST_ILLEGAL   = 2'd3
  } status_e;

  localparam int unsigned CpW = 21;

  // One classified word: up to two code points and an optional status.
  typedef struct packed {
    logic           pt0_en;
    logic [CpW-1:0] pt0;
    logic           pt1_en;
    logic [CpW-1:0] pt1;
    logic           st_en;
    status_e        status;
  } cmd_t;

  // Number of UTF-8 bytes minus one for a code point.
  function automatic logic [1:0] utf8_nm1(input logic [CpW-1:0] cp);
    logic [1:0] r;
    if (cp < 21'h80) begin
      r = 2'd0;
    end else if (cp < 21'h800) begin
      r = 2'd1;
    end else if (cp < 21'h10000) begin
      r = 2'd2;
    end else begin
      r = 2'd3;
    end
    return r;
  endfunction

  // Byte k of the UTF-8 sequence of a code point of nm1+1 bytes.
  function automatic logic [7:0] utf8_byte(input logic [CpW-1:0] cp,
                                           input logic [1:0] nm1,
                                           input logic [1:0] k);
    logic [7:0] r;
    logic [1:0] sh;
    sh = nm1 - k;
    if (k == 2'd0) begin
      unique case (nm1)
        2'd0: r = {1'b0, cp[6:0]};
        2'd1: r = {3'b110, cp[10:6]};
        2'd2: r = {4'b1110, cp[15:12]};
        default: r = {5'b11110, cp[20:18]};
      endcase
    end else begin
      unique case (sh)
        2'd0: r = {2'b10, cp[5:0]};
        2'd1: r = {2'b10, cp[11:6]};
        default: r = {2'b10, cp[17:12]};
      endcase
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/u2u8_front.sv =====
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 front end
// Accepts code units, pairs surrogates, checks capacity and builds commands.
// ----------------------------------------------------------------------------
module u2u8_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           strict_i,
  input  logic [15:0]    cap_i,
  input  logic           valid_i,
  output logic           ready_o,
  input  logic [15:0]    unit_i,
  input  logic           q_full_i,
  output logic           push_o,
  output u2u8_pkg::cmd_t cmd_o
);

  logic [9:0]  ph_q, ph_d;
  logic        pv_q, pv_d;
  logic [15:0] bw_q, bw_d;
  logic        halted_q, halted_d;

  logic        accept;
  logic        is_high, is_low, is_zero;
  logic        fresh;
  logic [15:0] bw_a;
  logic [16:0] sum_pair, sum_lone, sum_fresh;
  logic [20:0] pair_cp;
  logic        stop;
  u2u8_pkg::status_e stop_st;

  assign ready_o = !q_full_i;
  assign accept  = valid_i && ready_o;
  assign is_high = (unit_i[15:10] == 6'b110110);
  assign is_low  = (unit_i[15:10] == 6'b110111);
  assign is_zero = (unit_i == 16'd0);
  assign pair_cp = {1'b0, ph_q, unit_i[9:0]} + 21'h10000;
  assign sum_pair = {1'b0, bw_q} + 17'd4;
  assign sum_lone = {1'b0, bw_q} + 17'd3;

  always_comb begin
    ph_d     = ph_q;
    pv_d     = pv_q;
    bw_d     = bw_q;
    halted_d = halted_q;
    cmd_o    = '0;
    fresh    = 1'b0;
    bw_a     = bw_q;
    stop     = 1'b0;
    stop_st  = u2u8_pkg::ST_OK;
    sum_fresh = {1'b0, bw_q} + {15'd0, 2'd1};
    if (accept) begin
      if (halted_q) begin
        if (is_zero) begin
          halted_d = 1'b0;
          bw_d     = '0;
        end
      end else if (is_zero) begin
        cmd_o.st_en  = 1'b1;
        cmd_o.status = pv_q ? u2u8_pkg::ST_EXHAUSTED : u2u8_pkg::ST_OK;
        pv_d = 1'b0;
        bw_d = '0;
      end else begin
        fresh = 1'b1;
        if (pv_q) begin
          pv_d = 1'b0;
          if (is_low) begin
            fresh = 1'b0;
            if (sum_pair > {1'b0, cap_i}) begin
              stop    = 1'b1;
              stop_st = u2u8_pkg::ST_FULL;
            end else begin
              cmd_o.pt0_en = 1'b1;
              cmd_o.pt0    = pair_cp;
              bw_d         = sum_pair[15:0];
            end
          end else if (strict_i) begin
            fresh   = 1'b0;
            stop    = 1'b1;
            stop_st = u2u8_pkg::ST_ILLEGAL;
          end else if (sum_lone > {1'b0, cap_i}) begin
            fresh   = 1'b0;
            stop    = 1'b1;
            stop_st = u2u8_pkg::ST_FULL;
          end else begin
            cmd_o.pt0_en = 1'b1;
            cmd_o.pt0    = {5'd0, 6'b110110, ph_q};
            bw_a         = sum_lone[15:0];
            bw_d         = bw_a;
          end
        end
        sum_fresh = {1'b0, bw_a} + {15'd0, u2u8_pkg::utf8_nm1({5'd0, unit_i})} + 17'd1;
        if (fresh) begin
          if (is_high) begin
            ph_d = unit_i[9:0];
            pv_d = 1'b1;
          end else if (strict_i && is_low) begin
            stop    = 1'b1;
            stop_st = u2u8_pkg::ST_ILLEGAL;
          end else if (sum_fresh > {1'b0, cap_i}) begin
            stop    = 1'b1;
            stop_st = u2u8_pkg::ST_FULL;
          end else begin
            cmd_o.pt1_en = 1'b1;
            cmd_o.pt1    = {5'd0, unit_i};
            bw_d         = sum_fresh[15:0];
          end
        end
        if (stop) begin
          cmd_o.st_en  = 1'b1;
          cmd_o.status = stop_st;
          halted_d     = 1'b1;
          pv_d         = 1'b0;
        end
      end
    end
  end

  assign push_o = cmd_o.pt0_en || cmd_o.pt1_en || cmd_o.st_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q     <= '0;
      pv_q     <= 1'b0;
      bw_q     <= '0;
      halted_q <= 1'b0;
    end else begin
      ph_q     <= ph_d;
      pv_q     <= pv_d;
      bw_q     <= bw_d;
      halted_q <= halted_d;
    end
  end

endmodule

// ===== hw/rtl/u2u8_queue.sv =====
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 command queue
// Small circular buffer between the front end and the byte emitter.
// ----------------------------------------------------------------------------
module u2u8_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  u2u8_pkg::cmd_t wdata_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output u2u8_pkg::cmd_t rdata_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  u2u8_pkg::cmd_t  mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/u2u8_back.sv =====
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 byte emitter
// Turns queued commands into one output word per cycle while the queue holds a command and the output is not stalled.
// ----------------------------------------------------------------------------
module u2u8_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  u2u8_pkg::cmd_t cmd_i,
  output logic           pop_o,
  output logic           valid_o,
  input  logic           ready_i,
  output logic [7:0]     byte_o,
  output logic           byte_valid_o,
  output logic [1:0]     status_o,
  output logic           last_o
);

  logic [2:0]  done_q, done_d;
  logic [1:0]  idx_q, idx_d;
  logic        out_valid_q;
  logic [7:0]  byte_q;
  logic        bv_q;
  logic [1:0]  st_q;
  logic        last_q;

  logic [2:0]  parts, remain, cur;
  logic [20:0] cur_cp;
  logic [1:0]  nm1;
  logic        advance, emit, part_done;

  assign parts   = {cmd_i.st_en, cmd_i.pt1_en, cmd_i.pt0_en};
  assign remain  = parts & ~done_q;
  assign cur     = remain & (~remain + 3'd1);
  assign cur_cp  = cur[0] ? cmd_i.pt0 : cmd_i.pt1;
  assign nm1     = cur[2] ? 2'd0 : u2u8_pkg::utf8_nm1(cur_cp);
  assign advance = !out_valid_q || ready_i;
  assign emit    = advance && !empty_i;
  assign part_done = (idx_q == nm1);
  assign pop_o   = emit && part_done && (remain == cur);

  always_comb begin
    done_d = done_q;
    idx_d  = idx_q;
    if (emit) begin
      if (part_done) begin
        idx_d  = '0;
        done_d = (remain == cur) ? 3'd0 : (done_q | cur);
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q      <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      done_q <= done_d;
      idx_q  <= idx_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      if (cur[2]) begin
        byte_q <= '0;
        bv_q   <= 1'b0;
        st_q   <= cmd_i.status;
        last_q <= 1'b1;
      end else begin
        byte_q <= u2u8_pkg::utf8_byte(cur_cp, nm1, idx_q);
        bv_q   <= 1'b1;
        st_q   <= u2u8_pkg::ST_OK;
        last_q <= 1'b0;
      end
    end
  end

  assign valid_o      = out_valid_q;
  assign byte_o       = byte_q;
  assign byte_valid_o = bv_q;
  assign status_o     = st_q;
  assign last_o       = last_q;

endmodule

// ===== hw/rtl/utf16_to_utf8_encoder.sv =====
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 encoder
// Converts a stream of UTF-16 code units into UTF-8 bytes with a status word
// closing every string.
//
//   Channel  Direction  Contents
//   s_axis   in         code unit, zero ends the string
//   m_axis   out        UTF-8 byte or status word, tuser on a byte, tlast on status
//   apb      in/out     strict mode (0x0), target capacity (0x4)
//
// The front end accepts one code unit per cycle while the command queue has
// room. The emitter sends one output word per cycle while the output is not
// stalled; a unit makes from zero up to six output words.
// Reset clears the string state, the queue and the output register.
// Either side may stall; the queue holds QueueDepth commands.
// ----------------------------------------------------------------------------
module utf16_to_utf8_encoder #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,  // [15:0] code_unit
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,  // [7:0] out_byte, [9:8] status
  output logic        m_axis_tuser_o,  // [0] byte_valid
  output logic        m_axis_tlast_o,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);

  logic        strict_q;
  logic [15:0] cap_q;

  logic           q_full, q_empty, push, pop;
  u2u8_pkg::cmd_t push_cmd, head_cmd;
  logic [7:0]     out_byte;
  logic [1:0]     status;

  assign pready_o = 1'b1;
  assign prdata_o = paddr_i[2] ? {16'd0, cap_q} : {31'd0, strict_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strict_q <= 1'b1;
      cap_q    <= 16'd256;
    end else if (psel_i && penable_i && pwrite_i && pready_o) begin
      if (paddr_i[2]) begin
        cap_q <= pwdata_i[15:0];
      end else begin
        strict_q <= pwdata_i[0];
      end
    end
  end

  u2u8_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .strict_i (strict_q),
    .cap_i    (cap_q),
    .valid_i  (s_axis_tvalid_i),
    .ready_o  (s_axis_tready_o),
    .unit_i   (s_axis_tdata_i),
    .q_full_i (q_full),
    .push_o   (push),
    .cmd_o    (push_cmd)
  );

  u2u8_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_cmd),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .rdata_o (head_cmd)
  );

  u2u8_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (q_empty),
    .cmd_i        (head_cmd),
    .pop_o        (pop),
    .valid_o      (m_axis_tvalid_o),
    .ready_i      (m_axis_tready_i),
    .byte_o       (out_byte),
    .byte_valid_o (m_axis_tuser_o),
    .status_o     (status),
    .last_o       (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {6'd0, status, out_byte};

endmodule

// ===== hw/rtl/u2u8_checker.sv =====
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 encoder checker
// Port-level assertions on the output stream, bound to the top level.
// ----------------------------------------------------------------------------
module u2u8_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [15:0] m_axis_tdata_o,
  input logic        m_axis_tuser_o,
  input logic        m_axis_tlast_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) &&
      $stable(m_axis_tlast_o))
    else $error("Output word changed while stalled.");

  a_data_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |->
      m_axis_tdata_o[9:8] == 2'd0 && !m_axis_tlast_o)
    else $error("Data byte carries a status or end mark.");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |->
      m_axis_tlast_o && m_axis_tdata_o[7:0] == 8'd0)
    else $error("Status word is not a clean end of string.");

  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[15:10] == 6'd0)
    else $error("Padding bits of the output word are set.");

endmodule

bind utf16_to_utf8_encoder u2u8_checker u_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
